FILE: src/swhsr_pkg.sv
// package: shared types, codes and constants of the single-wire humidity sensor reader
package swhsr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int BIT_IDX_W  = $clog2(FRAME_BITS + 1);
  localparam int TICK_W     = 16;
  localparam int THR_W      = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0] START_LOW_RST  = 16'd18000;
  localparam logic [TICK_W-1:0] START_HIGH_RST = 16'd40;
  localparam logic [TICK_W-1:0] TIMEOUT_RST    = 16'd100;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 8'd40;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_LOW  = 2'd0,
    REG_START_HIGH = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_THRESHOLD  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_START_LOW  = 4'd1,
    PH_START_HIGH = 4'd2,
    PH_ACK_LOW    = 4'd3,
    PH_ACK_HIGH   = 4'd4,
    PH_BIT_LOW    = 4'd5,
    PH_BIT_HIGH   = 4'd6
  } phase_t;

  localparam logic [1:0] DRV_RELEASE = 2'd0;
  localparam logic [1:0] DRV_LOW     = 2'd1;
  localparam logic [1:0] DRV_HIGH    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_low_ticks;
    logic [TICK_W-1:0] start_high_ticks;
    logic [TICK_W-1:0] response_timeout_ticks;
    logic [THR_W-1:0]  one_threshold_ticks;
  } cfg_t;

endpackage

FILE: src/swhsr_cfg_regs.sv
// configuration register file of the sensor reader
module swhsr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swhsr_pkg::CFG_ADDR_W-1:0]   cfg_index,
  input  logic [swhsr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output swhsr_pkg::cfg_t                    cfg_o
);

  swhsr_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks        <= swhsr_pkg::START_LOW_RST;
      cfg_r.start_high_ticks       <= swhsr_pkg::START_HIGH_RST;
      cfg_r.response_timeout_ticks <= swhsr_pkg::TIMEOUT_RST;
      cfg_r.one_threshold_ticks    <= swhsr_pkg::THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        swhsr_pkg::REG_START_LOW:  cfg_r.start_low_ticks        <= cfg_data;
        swhsr_pkg::REG_START_HIGH: cfg_r.start_high_ticks       <= cfg_data;
        swhsr_pkg::REG_TIMEOUT:    cfg_r.response_timeout_ticks <= cfg_data;
        swhsr_pkg::REG_THRESHOLD:
          cfg_r.one_threshold_ticks <= cfg_data[swhsr_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/swhsr_core.sv
// measurement sequencer: one tick of the sensor protocol per step
module swhsr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  swhsr_pkg::in_t   tick_i,
  input  swhsr_pkg::cfg_t  cfg_i,
  output swhsr_pkg::out_t  res_o
);

  localparam int TW = swhsr_pkg::TICK_W;
  localparam int FB = swhsr_pkg::FRAME_BITS;
  localparam int BW = swhsr_pkg::BIT_IDX_W;

  swhsr_pkg::phase_t phase_r, phase_nxt;
  logic [TW-1:0]     tick_r, tick_nxt;
  logic [BW-1:0]     bit_idx_r, bit_idx_nxt;
  logic [FB-1:0]     shift_r, shift_nxt;
  logic [7:0]        hum_r, hum_nxt;
  logic [7:0]        temp_r, temp_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [1:0]        drive;
  logic              done;

  logic [TW-1:0] tick_inc;
  logic          expired;
  logic          bit_val;
  logic [FB-1:0] shift_new;
  logic [BW-1:0] bit_idx_inc;
  logic [7:0]    sum4;

  assign tick_inc    = tick_r + 1'b1;
  assign expired     = tick_r >= cfg_i.response_timeout_ticks;
  assign bit_val     = tick_r > {{(TW-swhsr_pkg::THR_W){1'b0}}, cfg_i.one_threshold_ticks};
  assign shift_new   = {shift_r[FB-2:0], bit_val};
  assign bit_idx_inc = bit_idx_r + 1'b1;
  assign sum4        = shift_new[39:32] + shift_new[31:24] + shift_new[23:16]
                     + shift_new[15:8];

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    hum_nxt     = hum_r;
    temp_nxt    = temp_r;
    status_nxt  = status_r;
    drive       = swhsr_pkg::DRV_RELEASE;
    done        = 1'b0;
    case (phase_r)
      swhsr_pkg::PH_IDLE: begin
        if (tick_i.start_request) begin
          phase_nxt   = swhsr_pkg::PH_START_LOW;
          tick_nxt    = '0;
          bit_idx_nxt = '0;
          shift_nxt   = '0;
          drive       = swhsr_pkg::DRV_LOW;
        end
      end
      swhsr_pkg::PH_START_LOW: begin
        if (tick_r >= cfg_i.start_low_ticks) begin
          phase_nxt = swhsr_pkg::PH_START_HIGH;
          tick_nxt  = '0;
          drive     = swhsr_pkg::DRV_HIGH;
        end else begin
          tick_nxt = tick_inc;
          drive    = swhsr_pkg::DRV_LOW;
        end
      end
      swhsr_pkg::PH_START_HIGH: begin
        if (tick_r >= cfg_i.start_high_ticks) begin
          phase_nxt = swhsr_pkg::PH_ACK_LOW;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
          drive    = swhsr_pkg::DRV_HIGH;
        end
      end
      swhsr_pkg::PH_ACK_LOW, swhsr_pkg::PH_BIT_LOW: begin
        if (tick_i.line_level) begin
          phase_nxt = (phase_r == swhsr_pkg::PH_ACK_LOW) ? swhsr_pkg::PH_ACK_HIGH
                                                         : swhsr_pkg::PH_BIT_HIGH;
          tick_nxt  = '0;
        end else if (expired) begin
          phase_nxt  = swhsr_pkg::PH_IDLE;
          tick_nxt   = '0;
          status_nxt = swhsr_pkg::ST_TIMEOUT;
          done       = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      swhsr_pkg::PH_ACK_HIGH: begin
        if (!tick_i.line_level) begin
          phase_nxt = swhsr_pkg::PH_BIT_LOW;
          tick_nxt  = '0;
        end else if (expired) begin
          phase_nxt  = swhsr_pkg::PH_IDLE;
          tick_nxt   = '0;
          status_nxt = swhsr_pkg::ST_TIMEOUT;
          done       = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      swhsr_pkg::PH_BIT_HIGH: begin
        if (!tick_i.line_level) begin
          shift_nxt   = shift_new;
          bit_idx_nxt = bit_idx_inc;
          tick_nxt    = '0;
          if (bit_idx_inc >= BW'(FB)) begin
            phase_nxt = swhsr_pkg::PH_IDLE;
            done      = 1'b1;
            // checksum is the low byte of the sum of the first four bytes
            if (sum4 == shift_new[7:0]) begin
              hum_nxt    = shift_new[39:32];
              temp_nxt   = shift_new[23:16];
              status_nxt = swhsr_pkg::ST_OK;
            end else begin
              status_nxt = swhsr_pkg::ST_CHECKSUM;
            end
          end else begin
            phase_nxt = swhsr_pkg::PH_BIT_LOW;
          end
        end else if (expired) begin
          phase_nxt  = swhsr_pkg::PH_IDLE;
          tick_nxt   = '0;
          status_nxt = swhsr_pkg::ST_TIMEOUT;
          done       = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: begin
        phase_nxt = swhsr_pkg::PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= swhsr_pkg::PH_IDLE;
      tick_r    <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      hum_r     <= '0;
      temp_r    <= '0;
      status_r  <= swhsr_pkg::ST_OK;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      hum_r     <= hum_nxt;
      temp_r    <= temp_nxt;
      status_r  <= status_nxt;
    end
  end

  always_comb begin
    res_o.line_drive  = drive;
    res_o.busy_res    = phase_nxt != swhsr_pkg::PH_IDLE;
    res_o.done_res    = done;
    res_o.status      = status_nxt;
    res_o.humidity    = hum_nxt;
    res_o.temperature = temp_nxt;
  end

endmodule

FILE: src/single_wire_humidity_sensor_reader.sv
// top level of the single-wire humidity sensor reader
// Each input beat is one microsecond tick carrying the sampled data line and a start
// request; each tick gives exactly one result beat with the line drive to apply, busy
// and done flags, the last status and the last good humidity and temperature bytes.
// The block takes one tick per clock cycle while the result side does not stall: a beat
// goes into an input register, the sequencer works the protocol step in one pass of
// logic as the tick leaves that register, and the result lands in the output register.
// Throughput is one beat per cycle, as the sequencer state updates once per tick; it
// drops only while the result side stalls. A request seen while busy is ignored.
// Configuration writes are taken every cycle and must only come while no tick is in
// flight.
module single_wire_humidity_sensor_reader (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  swhsr_pkg::in_t                    in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output swhsr_pkg::out_t                   out_data,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swhsr_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  logic [swhsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  swhsr_pkg::cfg_t cfg;
  swhsr_pkg::out_t res;

  // input register stage
  logic            s1_valid_r, s1_valid_nxt;
  swhsr_pkg::in_t  s1_data_r;
  // result register stage
  logic            out_valid_r, out_valid_nxt;
  swhsr_pkg::out_t out_data_r;

  logic advance;

  // the held tick moves on when the result register is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  swhsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // sequencer state steps once per tick, as the tick leaves the input register
  swhsr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .tick_i (s1_data_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/swhsr_checker.sv
// port-level checker for the sensor reader, bound to the top level
module swhsr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input swhsr_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a finishing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  // the line is only driven during a sequence
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.line_drive != swhsr_pkg::DRV_RELEASE) |-> out_data.busy_res)
    else $error("line driven while idle");

  // a finishing tick never drives the line
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.line_drive == swhsr_pkg::DRV_RELEASE)
    else $error("line driven on finishing tick");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
